[sv/sfsd_pkg.sv]
// shared constants and payload types of the static frame skip detector
package sfsd_pkg;

    // frame geometry and sampling
    localparam int FRAME_SIDE    = 392;
    localparam int SAMPLE_STRIDE = 4;
    localparam int PIXEL_LIMIT   = FRAME_SIDE * FRAME_SIDE;
    localparam int BANK_DEPTH    = (PIXEL_LIMIT + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE;

    localparam int PIX_W   = $clog2(PIXEL_LIMIT + 1);
    localparam int CNT_W   = $clog2(BANK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(BANK_DEPTH);
    localparam int PHASE_W = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;

    // pixel and difference widths
    localparam int CH_W    = 8;
    localparam int CHANNELS = 3;
    localparam int RGB_W   = CHANNELS * CH_W;
    localparam int PDIFF_W = CH_W + 2;
    localparam int DIFF_W  = 25;
    localparam logic [DIFF_W-1:0] DIFF_MAX = '1;

    // decision arithmetic
    localparam int THR_W    = 7;
    localparam int THR3_W   = THR_W + 2;
    localparam int SETTLE_W = 4;
    localparam int LHS_W    = DIFF_W + 4;
    localparam int RHS_W    = THR3_W + CNT_W;
    localparam int CMP_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_SKIP_ENABLE = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_SETTLE      = 2'd2
    } reg_index_t;

    localparam logic                SKIP_ENABLE_RST = 1'b1;
    localparam logic [THR_W-1:0]    THRESHOLD_RST   = 7'd10;
    localparam logic [SETTLE_W-1:0] SETTLE_RST      = 4'd8;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last_pixel;
    } pixel_t;

    typedef struct packed {
        logic                submit;
        logic                frame_static;
        logic [SETTLE_W-1:0] settle_remaining;
    } result_t;

endpackage

[sv/static_frame_skip_detector.sv]
// static frame skip detector: sampled frame difference against the last submitted frame
//
// Pixels of a downscaled RGB frame enter one per clock. Every SAMPLE_STRIDE-th pixel is
// compared with the matching sample of the reference frame (the last frame submitted for
// inference) and the absolute R, G and B differences are summed. Samples of the current
// frame go to the scratch bank of two BANK_DEPTH x 24 synchronous rams while the reference
// bank is read at the same sample index; a submitted frame flips the banks. On the pixel
// flagged last_pixel the block issues one result: the frame is static when skip_enable is set,
// 10 * sum <= threshold_tenths * 3 * samples, it has a reference and its nonzero sample count
// matches the reference's. A settle budget refills on motion and counts down on static
// frames; a static frame with the budget spent is not submitted. Within a frame the block
// takes one pixel every clock. After the last pixel it holds pixel_stall high while the
// ram read, difference, accumulate and multiply stages drain and the decision commits,
// and longer if the previous result is still waiting on result_stall. Pixels beyond
// FRAME_SIDE * FRAME_SIDE are ignored; the difference sum saturates at 2^25 - 1.
// No clearing pass is needed after reset: the reference is only compared once written.
// Registers (APB, byte address 4 * index): skip_enable, threshold_tenths, settle_load;
// write them only while no frame is in progress.
module static_frame_skip_detector
    import sfsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // pixel channel
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  pixel_t             pixel,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // configuration registers
    logic                skip_enable_reg;
    logic [THR_W-1:0]    threshold_reg;
    logic [THR3_W-1:0]   threshold_x3_reg;
    logic [SETTLE_W-1:0] settle_load_reg;

    // frame counters
    logic [PIX_W-1:0]    pixel_count_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [CNT_W-1:0]    sample_count_reg;
    logic [CNT_W-1:0]    frame_count_reg;
    logic                busy_reg;

    // reference bookkeeping
    logic                ref_bank_reg;
    logic                have_ref_reg;
    logic [CNT_W-1:0]    ref_count_reg;
    logic [SETTLE_W-1:0] settle_reg;

    // pipeline
    logic                s1_sample_reg;
    logic                s1_last_reg;
    logic [RGB_W-1:0]    s1_rgb_reg;
    logic [PDIFF_W-1:0]  s2_diff_reg;
    logic                s2_last_reg;
    logic [DIFF_W-1:0]   acc_reg;
    logic [DIFF_W-1:0]   dec_sum_reg;
    logic                sum_done_reg;
    logic [LHS_W-1:0]    lhs_reg;
    logic [RHS_W-1:0]    rhs_reg;
    logic                elig_reg;
    logic                dec_pend_reg;

    // result register
    logic                res_valid_reg;
    result_t             res_reg;

    // combinational
    logic                pix_accept;
    logic                in_frame;
    logic                sample_en;
    logic [CNT_W-1:0]    sample_count_next;
    logic [PHASE_W-1:0]  phase_next;
    logic                wr_bank0;
    logic                wr_bank1;
    logic [ADDR_W-1:0]   ram_addr;
    logic [RGB_W-1:0]    wr_rgb;
    logic [RGB_W-1:0]    rd_bank0;
    logic [RGB_W-1:0]    rd_bank1;
    logic [RGB_W-1:0]    ref_rgb;
    logic [PDIFF_W-1:0]  diff_next;
    logic [DIFF_W:0]     acc_sum;
    logic [DIFF_W-1:0]   acc_next;
    logic [LHS_W-1:0]    lhs_next;
    logic [RHS_W-1:0]    rhs_next;
    logic                elig_next;
    logic                commit;
    logic                frame_still;
    logic                submit_next;
    logic [SETTLE_W-1:0] settle_next;
    logic                cfg_write;
    reg_index_t          reg_idx;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

    // ---------------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_SKIP_ENABLE: prdata = PDATA_W'(skip_enable_reg);
            REG_THRESHOLD:   prdata = PDATA_W'(threshold_reg);
            REG_SETTLE:      prdata = PDATA_W'(settle_load_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // stage 0: sample selection, reference read, scratch write
    // ---------------------------------------------------------------------
    assign pixel_stall = busy_reg;
    assign pix_accept  = pixel_valid && !busy_reg;
    assign in_frame    = pixel_count_reg < PIX_W'(PIXEL_LIMIT);
    assign sample_en   = pix_accept && in_frame && (phase_reg == '0)
                         && (sample_count_reg < CNT_W'(BANK_DEPTH));

    assign sample_count_next = sample_count_reg + CNT_W'(sample_en);
    assign phase_next = (phase_reg == PHASE_W'(SAMPLE_STRIDE - 1)) ? '0
                                                                   : phase_reg + 1'b1;

    // reference bank is read, the other bank takes this frame's sample
    assign ram_addr = sample_count_reg[ADDR_W-1:0];
    assign wr_rgb   = {pixel.red, pixel.green, pixel.blue};
    assign wr_bank0 = sample_en && ref_bank_reg;
    assign wr_bank1 = sample_en && !ref_bank_reg;

    sfsd_ram #(
        .WIDTH (RGB_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank0 (
        .clk     (clk),
        .wr_en   (wr_bank0),
        .wr_addr (ram_addr),
        .wr_data (wr_rgb),
        .rd_addr (ram_addr),
        .rd_data (rd_bank0)
    );

    sfsd_ram #(
        .WIDTH (RGB_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank1 (
        .clk     (clk),
        .wr_en   (wr_bank1),
        .wr_addr (ram_addr),
        .wr_data (wr_rgb),
        .rd_addr (ram_addr),
        .rd_data (rd_bank1)
    );

    // ---------------------------------------------------------------------
    // stage 1: per-sample absolute difference
    // bank select is stable for the whole frame, it only flips while busy
    // ---------------------------------------------------------------------
    assign ref_rgb = ref_bank_reg ? rd_bank1 : rd_bank0;

    always_comb
    begin
        diff_next = '0;
        if (s1_sample_reg)
        begin
            diff_next = PDIFF_W'(abs_diff(s1_rgb_reg[3*CH_W-1:2*CH_W],
                                          ref_rgb[3*CH_W-1:2*CH_W]))
                      + PDIFF_W'(abs_diff(s1_rgb_reg[2*CH_W-1:CH_W],
                                          ref_rgb[2*CH_W-1:CH_W]))
                      + PDIFF_W'(abs_diff(s1_rgb_reg[CH_W-1:0], ref_rgb[CH_W-1:0]));
        end
    end

    // ---------------------------------------------------------------------
    // stage 2: saturating accumulate
    // ---------------------------------------------------------------------
    assign acc_sum  = {1'b0, acc_reg} + (DIFF_W + 1)'(s2_diff_reg);
    assign acc_next = acc_sum[DIFF_W] ? DIFF_MAX : acc_sum[DIFF_W-1:0];

    // ---------------------------------------------------------------------
    // stage 3: both sides of 10 * sum <= threshold * 3 * samples
    // ---------------------------------------------------------------------
    assign lhs_next  = (LHS_W'(dec_sum_reg) << 3) + (LHS_W'(dec_sum_reg) << 1);
    assign rhs_next  = RHS_W'(threshold_x3_reg) * RHS_W'(frame_count_reg);
    assign elig_next = skip_enable_reg && have_ref_reg && (frame_count_reg != '0)
                       && (frame_count_reg == ref_count_reg);

    // ---------------------------------------------------------------------
    // stage 4: decision, settle budget and bank flip
    // ---------------------------------------------------------------------
    assign commit      = dec_pend_reg && (!res_valid_reg || !result_stall);
    assign frame_still = elig_reg && (CMP_W'(lhs_reg) <= CMP_W'(rhs_reg));

    always_comb
    begin
        settle_next = settle_reg;
        submit_next = 1'b1;
        if (frame_still)
        begin
            if (settle_reg == '0)
            begin
                submit_next = 1'b0;
            end
            else
            begin
                settle_next = settle_reg - 1'b1;
            end
        end
        else
        begin
            settle_next = settle_load_reg;
        end
    end

    // ---------------------------------------------------------------------
    // registers with reset
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_enable_reg   <= SKIP_ENABLE_RST;
            threshold_reg     <= THRESHOLD_RST;
            threshold_x3_reg  <= THR3_W'(THRESHOLD_RST) * THR3_W'(CHANNELS);
            settle_load_reg   <= SETTLE_RST;
            pixel_count_reg   <= '0;
            phase_reg         <= '0;
            sample_count_reg  <= '0;
            busy_reg          <= 1'b0;
            ref_bank_reg      <= 1'b0;
            have_ref_reg      <= 1'b0;
            ref_count_reg     <= '0;
            settle_reg        <= '0;
            s1_sample_reg     <= 1'b0;
            s1_last_reg       <= 1'b0;
            s2_diff_reg       <= '0;
            s2_last_reg       <= 1'b0;
            acc_reg           <= '0;
            sum_done_reg      <= 1'b0;
            dec_pend_reg      <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_write)
            begin
                unique case (reg_idx)
                    REG_SKIP_ENABLE: skip_enable_reg <= pwdata[0];
                    REG_THRESHOLD:
                    begin
                        threshold_reg    <= pwdata[THR_W-1:0];
                        threshold_x3_reg <= THR3_W'(pwdata[THR_W-1:0]) * THR3_W'(CHANNELS);
                    end
                    REG_SETTLE:      settle_load_reg <= pwdata[SETTLE_W-1:0];
                    default:         ;
                endcase
            end

            // frame counters
            if (pix_accept)
            begin
                if (pixel.last_pixel)
                begin
                    pixel_count_reg  <= '0;
                    phase_reg        <= '0;
                    sample_count_reg <= '0;
                    busy_reg         <= 1'b1;
                end
                else if (in_frame)
                begin
                    pixel_count_reg  <= pixel_count_reg + 1'b1;
                    phase_reg        <= phase_next;
                    sample_count_reg <= sample_count_next;
                end
            end

            // pipeline control
            s1_sample_reg <= sample_en;
            s1_last_reg   <= pix_accept && pixel.last_pixel;
            s2_diff_reg   <= diff_next;
            s2_last_reg   <= s1_last_reg;
            sum_done_reg  <= s2_last_reg;

            if (s2_last_reg)
            begin
                acc_reg <= '0;
            end
            else
            begin
                acc_reg <= acc_next;
            end

            if (sum_done_reg)
            begin
                dec_pend_reg <= 1'b1;
            end
            else if (commit)
            begin
                dec_pend_reg <= 1'b0;
            end

            // decision commit
            if (commit)
            begin
                busy_reg   <= 1'b0;
                settle_reg <= settle_next;
                if (submit_next)
                begin
                    ref_bank_reg  <= !ref_bank_reg;
                    have_ref_reg  <= 1'b1;
                    ref_count_reg <= frame_count_reg;
                end
            end

            // result register
            if (commit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_rgb_reg <= wr_rgb;
            if (pixel.last_pixel)
            begin
                frame_count_reg <= sample_count_next;
            end
        end
        if (s2_last_reg)
        begin
            dec_sum_reg <= acc_next;
        end
        if (sum_done_reg)
        begin
            lhs_reg  <= lhs_next;
            rhs_reg  <= rhs_next;
            elig_reg <= elig_next;
        end
        if (commit)
        begin
            res_reg.submit           <= submit_next;
            res_reg.frame_static     <= frame_still;
            res_reg.settle_remaining <= settle_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

[sv/sfsd_ram.sv]
// generic simple dual-port ram with registered read
module sfsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[tb/static_frame_skip_detector_test.sv]
// self-checking testbench for the static frame skip detector: pixel stream in, frame decisions out
`timescale 1ns / 100ps

module static_frame_skip_detector_test
    import sfsd_pkg::*;
();

    // stimulus shaping
    localparam int MAX_LEN         = 48;    // longest frame in the random part
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 95;    // at least this many pixels per random phase
    localparam int QUEUE_DEPTH     = 256;   // how far the generator runs ahead of the driver
    localparam int DRAIN_CYCLES    = 8;     // covers the decision drain with margin
    localparam int QUIET_LIMIT     = 2000;  // cycles with no item moving before giving up
    localparam int SPARE_REG_INDEX = 3;     // first index past the register list

    localparam int unsigned ACC_CEIL = (1 << DIFF_W) - 1;

    // dut inputs, all known from time zero
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                pixel_valid  = 1'b0;
    logic                pixel_stall;
    pixel_t              pixel        = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    result_t             result;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    static_frame_skip_detector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // pixels waiting for the driver and decisions waiting for the dut
    pixel_t  pending_pixels[$];
    result_t expected_decisions[$];

    // idling knobs, percent chance of starting a burst
    int gap_pct   = 0;
    int stall_pct = 0;
    int gap_left  = 0;
    int stall_left = 0;

    int errors        = 0;
    int quiet_cycles  = 0;
    int decisions_checked = 0;
    int frames_judged = 0;
    int frames_still  = 0;
    int frames_held   = 0;

    // ------------------------------------------------------------------
    // predictor state: two sample banks, the reference bookkeeping,
    // the per-frame counters and a shadow of the registers
    // ------------------------------------------------------------------
    bit [RGB_W-1:0]     sample_bank [2][BANK_DEPTH];
    bit                 ref_bank    = 1'b0;
    bit                 have_ref    = 1'b0;
    int unsigned        ref_samples = 0;
    int unsigned        acc         = 0;
    int unsigned        pix_cnt     = 0;
    int unsigned        smp_cnt     = 0;
    logic [SETTLE_W-1:0] settle     = '0;

    logic                cfg_skip   = SKIP_ENABLE_RST;
    logic [THR_W-1:0]    cfg_thr    = THRESHOLD_RST;
    logic [SETTLE_W-1:0] cfg_settle = SETTLE_RST;

    // scene the random frames are jittered around
    logic [RGB_W-1:0] scene_rgb [MAX_LEN];

    function automatic int unsigned chan_delta(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        return (a >= b) ? int'(a - b) : int'(b - a);
    endfunction

    // random 24-bit color
    function automatic logic [RGB_W-1:0] any_rgb();
        return RGB_W'($urandom_range(24'hFFFFFF));
    endfunction

    // advance the predictor by one accepted pixel, queue a decision on the last one
    task automatic judge_pixel(input pixel_t p);
        logic [RGB_W-1:0]  old_rgb;
        int unsigned       delta;
        longint unsigned   lhs;
        longint unsigned   rhs;
        bit                still;
        bit                go;
        result_t           d;
        // pixels beyond the frame limit are dropped and the counter sticks
        if (pix_cnt < PIXEL_LIMIT)
        begin
            if (pix_cnt % SAMPLE_STRIDE == 0 && smp_cnt < BANK_DEPTH)
            begin
                old_rgb = sample_bank[ref_bank][smp_cnt];
                delta = chan_delta(p.red, old_rgb[23:16]) +
                        chan_delta(p.green, old_rgb[15:8]) +
                        chan_delta(p.blue, old_rgb[7:0]);
                acc = (acc + delta > ACC_CEIL) ? ACC_CEIL : acc + delta;
                sample_bank[!ref_bank][smp_cnt] = {p.red, p.green, p.blue};
                smp_cnt++;
            end
            pix_cnt++;
        end
        if (p.last_pixel)
        begin
            // static only against a reference of the same sample count
            still = 1'b0;
            if (cfg_skip && have_ref && smp_cnt != 0 && smp_cnt == ref_samples)
            begin
                lhs = longint'(acc) * 10;
                rhs = longint'(cfg_thr) * CHANNELS * smp_cnt;
                still = (lhs <= rhs);
            end
            // settle budget: refill on motion, spend on static frames
            if (still)
            begin
                if (settle == 0)
                begin
                    go = 1'b0;
                end
                else
                begin
                    settle = settle - 1'b1;
                    go = 1'b1;
                end
            end
            else
            begin
                settle = cfg_settle;
                go = 1'b1;
            end
            // a submitted frame becomes the reference
            if (go)
            begin
                ref_bank    = !ref_bank;
                ref_samples = smp_cnt;
                have_ref    = 1'b1;
            end
            d.submit           = go;
            d.frame_static     = still;
            d.settle_remaining = settle;
            expected_decisions.push_back(d);
            frames_judged++;
            if (still)
                frames_still++;
            if (!go)
                frames_held++;
            acc     = 0;
            pix_cnt = 0;
            smp_cnt = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // pixel driver: feeds the dut from the queue, holds the item while stalled,
    // and may open an idle gap after each item
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel       <= '0;
            gap_left    <= 0;
        end
        else if (!pixel_valid || !pixel_stall)
        begin
            if (gap_left != 0)
            begin
                pixel_valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end
            else if (pending_pixels.size() != 0)
            begin
                pixel       <= pending_pixels.pop_front();
                pixel_valid <= 1'b1;
                if (gap_pct != 0 && $urandom_range(99) < gap_pct)
                    gap_left <= $urandom_range(4, 1);
            end
            else
            begin
                pixel_valid <= 1'b0;
            end
        end
    end

    // result backpressure in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(3);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // every accepted pixel goes through the predictor
    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && !pixel_stall)
            judge_pixel(pixel);
    end

    // compare each accepted decision with the oldest prediction
    always @(posedge clk)
    begin : check_decisions
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_decisions.size() == 0)
            begin
                $error("decision with no frame outstanding: submit=%0d static=%0d settle=%0d",
                       result.submit, result.frame_static, result.settle_remaining);
                errors++;
            end
            else
            begin
                want = expected_decisions.pop_front();
                decisions_checked++;
                if (result.submit !== want.submit)
                begin
                    $error("submit: expected %0d, got %0d", want.submit, result.submit);
                    errors++;
                end
                if (result.frame_static !== want.frame_static)
                begin
                    $error("frame_static: expected %0d, got %0d",
                           want.frame_static, result.frame_static);
                    errors++;
                end
                if (result.settle_remaining !== want.settle_remaining)
                begin
                    $error("settle_remaining: expected %0d, got %0d",
                           want.settle_remaining, result.settle_remaining);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles where neither channel moves an item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles, %0d decisions outstanding",
                         quiet_cycles, expected_decisions.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // queue one pixel, throttled so the generator stays a little ahead
    task automatic push_pixel(input logic [RGB_W-1:0] rgb, input bit last);
        while (pending_pixels.size() >= QUEUE_DEPTH)
            @(posedge clk);
        pending_pixels.push_back(pixel_t'{rgb[23:16], rgb[15:8], rgb[7:0], last});
    endtask

    // wait until every pixel is in and every decision is out, then let the pipe settle
    task automatic drain_all();
        while (pending_pixels.size() != 0 || pixel_valid || expected_decisions.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle, access cycle, shadow updated at the write edge
    task automatic write_reg(input int index, input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * index);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_SKIP_ENABLE: cfg_skip   = data[0];
            REG_THRESHOLD:   cfg_thr    = data[THR_W-1:0];
            REG_SETTLE:      cfg_settle = data[SETTLE_W-1:0];
            default: ;      // unmapped index, nothing changes
        endcase
    endtask

    task automatic set_config(input int skip, input int thr, input int budget);
        write_reg(REG_SKIP_ENABLE, skip);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_SETTLE, budget);
    endtask

    function automatic logic [CH_W-1:0] jitter(input logic [CH_W-1:0] level, input int spread);
        int v;
        v = int'(level) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        else if (v > 255)
            v = 255;
        return v[CH_W-1:0];
    endfunction

    // one frame near the current scene, or fully random when it is a motion frame
    task automatic push_scene_frame(input int len, input int spread, input bit motion);
        logic [RGB_W-1:0] rgb;
        for (int i = 0; i < len; i++)
        begin
            if (motion)
                rgb = any_rgb();
            else
                rgb = {jitter(scene_rgb[i][23:16], spread),
                       jitter(scene_rgb[i][15:8], spread),
                       jitter(scene_rgb[i][7:0], spread)};
            push_pixel(rgb, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int  scene_left;
        int  scene_len;
        int  len;
        int  phase_items;
        int  kind;
        bit  paused;

        scene_left = 0;
        scene_len  = 1;
        paused     = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames at reset values, no idling
        gap_pct   = 0;
        stall_pct = 0;
        push_pixel(24'h000000, 1'b1);               // first frame, no reference, submitted
        push_pixel(24'h000000, 1'b1);               // zero difference, budget spent by one
        push_pixel(24'hFFFFFF, 1'b1);               // full-scale difference, motion
        push_pixel(24'hFFFFFF, 1'b0);               // one sample in four pixels, static
        push_pixel(24'h000000, 1'b0);
        push_pixel(24'h123456, 1'b0);
        push_pixel(24'hABCDEF, 1'b1);
        repeat (7) push_pixel(any_rgb(), 1'b0);
        push_pixel(any_rgb(), 1'b1);                // two samples, count mismatch
        drain_all();

        // no settle budget, threshold above its nominal range
        set_config(1, 127, 0);
        push_pixel(24'h808080, 1'b1);               // sample count mismatch, submitted, budget 0
        push_pixel(24'h8A8A8A, 1'b1);               // static with no budget, held back
        push_pixel(24'h000000, 1'b1);               // compared against the held reference
        drain_all();

        // detection off: always moving
        set_config(0, 0, 0);
        push_pixel(24'h000000, 1'b1);
        drain_all();

        // zero threshold with detection on, plus a write past the register list
        write_reg(REG_SKIP_ENABLE, 1);
        write_reg(SPARE_REG_INDEX, $urandom);
        push_pixel(24'h000000, 1'b1);               // exact repeat, static at threshold 0
        drain_all();

        // random phases: scenes with jittered frames, motion frames and length changes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 0)
                set_config(1, 80, 15);
            else
                set_config(($urandom_range(5) != 0) ? 1 : 0,
                           ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(40),
                           ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom_range(15));

            // no idling in the last phase, otherwise alternate none, light, heavy
            kind = (p == NUM_PHASES - 1) ? 0 : p % 3;
            gap_pct   = (kind == 0) ? 0 : (kind == 1) ? 15 : 40;
            stall_pct = (kind == 0) ? 0 : (kind == 1) ? 15 : 50;

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if (scene_left == 0)
                begin
                    kind = $urandom_range(7);
                    for (int i = 0; i < MAX_LEN; i++)
                        scene_rgb[i] = (kind == 0) ? 24'h000000 :
                                       (kind == 1) ? 24'hFFFFFF : any_rgb();
                    scene_len  = ($urandom_range(7) == 0) ? $urandom_range(MAX_LEN, 25)
                                                          : $urandom_range(24, 1);
                    scene_left = $urandom_range(10, 2);
                end
                // occasional length change, which may or may not change the sample count
                len = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN, 1) : scene_len;
                push_scene_frame(len, $urandom_range(4), $urandom_range(11) == 0);
                phase_items += len;
                scene_left--;

                // in phase 3 only, the sender holds off once mid-phase until every decision is back
                if (p == 3 && !paused && phase_items >= PHASE_ITEMS / 2)
                begin
                    drain_all();
                    paused = 1'b1;
                end
            end
            drain_all();
        end

        $display("covered first-frame, mismatch, held and threshold corner frames: %0d judged",
                 frames_judged);
        $display("%0d static, %0d held back, %0d decisions checked with idling on and off",
                 frames_still, frames_held, decisions_checked);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
